[sv/boot_ram_command_controller_defines.svh]
// ---------------------------------------------------------------------------
// Boot controller assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BOOT_RAM_COMMAND_CONTROLLER_DEFINES_SVH
`define BOOT_RAM_COMMAND_CONTROLLER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/brcc_pkg.sv]
// ---------------------------------------------------------------------------
// Boot controller package
// Types, constants and codes shared by the boot controller modules.
// ---------------------------------------------------------------------------
package brcc_pkg;

    localparam int RamBytes  = 64;
    localparam int Channels  = 5;
    localparam int RomWords  = 512;
    localparam int RamAw     = $clog2(RamBytes);
    localparam int RomAw     = $clog2(RomWords);
    localparam int ChW       = $clog2(Channels + 1);
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 48;

    localparam logic [CfgIdxW-1:0] CFG_EXPECTED = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SEED1    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SEED2    = 2'd2;

    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_PRELOAD = 2'd2;
    localparam logic [1:0] CMD_SRESET  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RSV_RD  = 2'd1;
    localparam logic [1:0] ST_ROM_WR  = 2'd2;
    localparam logic [1:0] ST_RSV_WR  = 2'd3;

    // offsets within the region
    localparam logic [19:0] OFF_RAM = 20'h007C0;
    localparam logic [19:0] OFF_RSV = 20'h00800;

    localparam logic [7:0] MARK_END   = 8'hFE;
    localparam logic [7:0] MARK_RESET = 8'hFD;
    localparam logic [7:0] MARK_SKIP  = 8'hFF;
    localparam logic [7:0] MARK_NONE  = 8'h00;
    localparam logic [RamAw-1:0] CMD_AT  = RamAw'(RamBytes - 1);
    localparam logic [RamAw-1:0] CSUM_AT = RamAw'(48);
    localparam logic [RamAw-1:0] SEED_AT = RamAw'(38);

    localparam int BIT_JOY  = 0;
    localparam int BIT_CHAL = 1;
    localparam int BIT_TERM = 3;
    localparam int BIT_LOCK = 4;
    localparam int BIT_ACQ  = 5;
    localparam int BIT_RUN  = 6;
    localparam int BIT_DONE = 7;

    localparam logic [47:0] EXPECTED_RESET = 48'hA536C0F1D859;
    localparam logic [7:0]  SEED_RESET     = 8'h3F;

    typedef struct packed {
        logic [1:0]  command;
        logic [19:0] byte_offset;
        logic [31:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [31:0]         read_data;
        logic [1:0]          access_status;
        logic                checksum_mismatch;
        logic                rom_locked;
        logic [Channels-1:0] active_channels;
        logic [Channels-1:0] reset_channels;
    } t_out_word;

endpackage

[sv/brcc_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module brcc_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/boot_ram_command_controller.sv]
// A ROM read or preload passes S_ROMRD and S_FIN, a RAM read takes four bytes
// in S_RDB, and a rejected access goes straight to S_OUT. A RAM write runs a
// byte-serial sequencer over the single-port command RAM: byte writes, a
// command byte read, then an optional checksum take and frame parse. A soft
// reset reruns the RAM clear. One word at a time; the input reopens once the
// result register is loaded. Reset is synchronous, active low, starts RAM clear.
// ---------------------------------------------------------------------------
// Boot ROM and command RAM controller
// Bus word access to a boot ROM window and a byte-wide command RAM.
// ---------------------------------------------------------------------------
`include "boot_ram_command_controller_defines.svh"
module boot_ram_command_controller
    import brcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_data,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxW-1:0]    i_cfg_idx,
    input  logic [CfgDataW-1:0]   i_cfg_data
);
    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_ROMRD = 14'b00000000000100,
        S_RDB   = 14'b00000000001000,
        S_WRB   = 14'b00000000010000,
        S_CMDRD = 14'b00000000100000,
        S_CMDW  = 14'b00000001000000,
        S_ACQ   = 14'b00000010000000,
        S_PTX   = 14'b00000100000000,
        S_PTXW  = 14'b00001000000000,
        S_PRX   = 14'b00010000000000,
        S_PRXW  = 14'b00100000000000,
        S_FIN   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [47:0] r_expected;
    logic [7:0]  r_seed1, r_seed2;
    logic        r_lock, n_lock;
    logic [63:0] r_csum, n_csum;
    logic [Channels-1:0] r_act, n_act, r_rst, n_rst;
    t_in_word    r_in, n_in;
    logic [RamAw:0] r_cnt, n_cnt;       // byte counter / walk pointer
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_tx, n_tx;
    logic [ChW-1:0] r_ch, n_ch;
    logic [31:0] r_rd, n_rd;
    logic        r_mis, n_mis;
    logic [1:0]  r_st, n_st;
    logic        r_ov, n_ov;
    t_out_word   r_out, n_out;

    logic        ram_we, rom_we;
    logic [RamAw-1:0] ram_addr;
    logic [7:0]  ram_wd, ram_rd;
    logic [31:0] rom_rd;
    logic [RamAw:0] nxt;
    logic [RamAw-1:0] wbase;
    logic [ChW-1:0] ch_hi;

    brcc_ram #(.Width(8), .Depth(RamBytes)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(ram_wd),
        .o_rdata(ram_rd)
    );
    brcc_ram #(.Width(32), .Depth(RomWords)) u_rom (
        .i_clk(i_clk), .i_we(rom_we), .i_addr(r_in.byte_offset[RomAw+1:2]),
        .i_wdata(r_in.write_data), .o_rdata(rom_rd)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign wbase   = {r_in.byte_offset[RamAw-1:2], 2'b00};
    assign rom_we  = (r_state == S_ROMRD) && (r_in.command == CMD_PRELOAD);
    assign nxt     = r_cnt + 1'b1 + (RamAw+1)'(r_tx[5:0]) + (RamAw+1)'(ram_rd[5:0]);
    assign ch_hi   = r_ch - 1'b1;

    always_comb begin
        n_state = r_state; n_lock = r_lock; n_csum = r_csum;
        n_act = r_act; n_rst = r_rst; n_in = r_in; n_cnt = r_cnt;
        n_cmd = r_cmd; n_tx = r_tx; n_ch = r_ch; n_rd = r_rd; n_mis = r_mis;
        n_st = r_st; n_ov = r_ov; n_out = r_out;
        ram_we = 1'b0; ram_addr = r_cnt[RamAw-1:0]; ram_wd = '0;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_wd = (r_cnt[RamAw-1:0] == SEED_AT) ? r_seed1 :
                         (r_cnt[RamAw-1:0] == SEED_AT + 1'b1) ? r_seed2 : 8'h00;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[RamAw-1:0] == CMD_AT) begin
                    n_state = (r_in.command == CMD_SRESET) ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_in = i_data; n_rd = '0; n_mis = 1'b0; n_st = ST_OK;
                    n_cnt = '0; n_state = S_OUT;
                    case (i_data.command)
                        CMD_READ: begin
                            if (i_data.byte_offset < OFF_RAM) n_state = S_ROMRD;
                            else if (i_data.byte_offset < OFF_RSV) n_state = S_RDB;
                            else n_st = ST_RSV_RD;
                        end
                        CMD_WRITE: begin
                            if (i_data.byte_offset < OFF_RAM) n_st = ST_ROM_WR;
                            else if (i_data.byte_offset < OFF_RSV) n_state = S_WRB;
                            else n_st = ST_RSV_WR;
                        end
                        CMD_PRELOAD: begin
                            if (i_data.byte_offset < OFF_RSV) n_state = S_ROMRD;
                            else n_st = ST_RSV_WR;
                        end
                        default: begin
                            n_lock = 1'b0; n_csum = '0; n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_ROMRD: begin
                // read issued this cycle; data lands next cycle
                n_state = S_FIN;
            end
            S_RDB: begin
                ram_addr = wbase | r_cnt[RamAw-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt != '0) n_rd = {r_rd[23:0], ram_rd};
                if (r_cnt == (RamAw+1)'(4)) n_state = S_OUT;
            end
            S_WRB: begin
                ram_we = 1'b1;
                ram_addr = wbase | r_cnt[RamAw-1:0];
                ram_wd = r_in.write_data[31 - 8*r_cnt[1:0] -: 8];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt = '0; n_state = S_CMDRD;
                end
            end
            S_CMDRD: begin
                ram_addr = CMD_AT;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[0]) begin
                    n_cmd = ram_rd;
                    n_cnt = '0;
                    if (ram_rd == 8'h00) begin
                        n_state = S_OUT;
                    end else begin
                        n_cmd[BIT_DONE] = 1'b0; n_cmd[BIT_TERM] = 1'b0;
                        n_cmd[BIT_CHAL] = 1'b0;
                        if (ram_rd[BIT_LOCK]) n_lock = 1'b1;
                        n_cmd[BIT_LOCK] = 1'b0;
                        n_state = ram_rd[BIT_ACQ] ? S_ACQ : S_CMDW;
                    end
                end
            end
            S_ACQ: begin
                // even cycle: read byte; odd cycle: capture and zero
                ram_addr = CSUM_AT + RamAw'(r_cnt[3:1]);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[0]) begin
                    n_csum = {n_csum[55:0], ram_rd};
                    ram_we = 1'b1;
                    if (r_cnt[3:0] == 4'd15) begin
                        n_cmd[BIT_ACQ] = 1'b0; n_cmd[BIT_DONE] = 1'b1;
                        n_state = S_CMDW;
                    end
                end else if (r_cnt == '0) begin
                    n_csum = '0;
                end
            end
            S_CMDW: begin
                if (r_cmd[BIT_RUN]) begin
                    n_mis = (r_csum != {16'h0, r_expected});
                end
                n_cnt = '0; n_ch = '0;
                // the parse sees the command byte as written; write it back after
                if (r_cmd[BIT_JOY]) begin
                    n_cmd[BIT_JOY] = 1'b0;
                    n_act = '0; n_rst = '0; n_state = S_PTX;
                end else begin
                    ram_we = 1'b1; ram_addr = CMD_AT;
                    ram_wd = r_cmd & ~(8'(1) << BIT_RUN) & ~(8'(1) << BIT_JOY);
                    n_state = S_OUT;
                end
            end
            S_PTX: begin
                if (r_ch == ChW'(Channels) || r_cnt >= (RamAw+1)'(RamBytes)) begin
                    n_state = S_CMDW;
                end else begin
                    n_state = S_PTXW;
                end
            end
            S_PTXW: begin
                n_tx = ram_rd;
                n_state = S_PTX;
                if (ram_rd == MARK_END) begin
                    n_state = S_CMDW;
                end else if (ram_rd == MARK_SKIP) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (ram_rd == MARK_RESET || ram_rd == MARK_NONE) begin
                    if (ram_rd == MARK_RESET) n_rst[r_ch[ChW-1:0]] = 1'b1;
                    n_cnt = r_cnt + 1'b1; n_ch = r_ch + 1'b1;
                end else begin
                    n_act[r_ch[ChW-1:0]] = 1'b1; n_ch = r_ch + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    n_state = S_PRX;
                end
            end
            S_PRX: begin
                if (r_cnt >= (RamAw+1)'(RamBytes)) begin
                    n_act[ch_hi] = 1'b0; n_rst[ch_hi] = 1'b0; n_state = S_CMDW;
                end else begin
                    n_state = S_PRXW;
                end
            end
            S_PRXW: begin
                if (nxt >= (RamAw+1)'(RamBytes) ||
                    ({1'b0, r_cnt} + 1'b1 + (RamAw+2)'(r_tx[5:0]) +
                     (RamAw+2)'(ram_rd[5:0])) >= (RamAw+2)'(RamBytes)) begin
                    n_act[ch_hi] = 1'b0; n_rst[ch_hi] = 1'b0; n_state = S_CMDW;
                end else begin
                    n_cnt = nxt; n_state = S_PTX;
                end
            end
            S_FIN: begin
                if (r_in.command == CMD_READ && !r_lock) n_rd = rom_rd;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_out.read_data = r_rd;
                    n_out.access_status = r_st;
                    n_out.checksum_mismatch = r_mis;
                    n_out.rom_locked = r_lock;
                    n_out.active_channels = r_act;
                    n_out.reset_channels = r_rst;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_lock <= 1'b0; r_csum <= '0;
            r_act <= '0; r_rst <= '0; r_cnt <= '0; r_ov <= 1'b0;
            r_expected <= EXPECTED_RESET; r_seed1 <= SEED_RESET; r_seed2 <= SEED_RESET;
            r_in.command <= CMD_READ;
        end else begin
            r_state <= n_state; r_lock <= n_lock; r_csum <= n_csum;
            r_act <= n_act; r_rst <= n_rst; r_cnt <= n_cnt; r_ov <= n_ov;
            r_in.command <= n_in.command;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EXPECTED: r_expected <= i_cfg_data;
                    CFG_SEED1:    r_seed1 <= i_cfg_data[7:0];
                    CFG_SEED2:    r_seed2 <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        r_in.byte_offset <= n_in.byte_offset; r_in.write_data <= n_in.write_data;
        r_cmd <= n_cmd; r_tx <= n_tx; r_ch <= n_ch; r_rd <= n_rd;
        r_mis <= n_mis; r_st <= n_st; r_out <= n_out;
    end

    `BRC_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall,
        "input accepted while busy")
    `BRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data),
        "stalled result changed")
    `BRC_ASSERT_IMP(a_rd_zero, i_clk, i_rst_n, o_valid && o_data.access_status != ST_OK,
        o_data.read_data == 32'h0, "nonzero read data on error")
endmodule
